@@ rtl/fed_pkg.sv @@
// ----------------------------------------------------------------------------
// fed_pkg
// shared constants and types for the flag/escape byte deframer
// ----------------------------------------------------------------------------
package fed_pkg;

  // framing bytes
  localparam logic [7:0] FLAG_BYTE     = 8'h7E;
  localparam logic [7:0] ESC_BYTE      = 8'h7D;
  localparam logic [7:0] ESC_FLAG_CODE = 8'h5E;
  localparam logic [7:0] ESC_ESC_CODE  = 8'h5D;

  // length counter and limit register
  localparam int unsigned LEN_W = 24;
  localparam logic [LEN_W-1:0] LIMIT_RESET = LEN_W'(1024 * 1024 * 10);

  // output tdata: data byte, error flag, raw length, padded to whole bytes
  localparam int unsigned OUT_FIELDS_W = 8 + 1 + LEN_W;
  localparam int unsigned OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  // result kinds carried on tuser
  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_END   = 2'd1,
    KIND_ABORT = 2'd2
  } kind_e;

endpackage

@@ rtl/flag_escape_deframer_top.sv @@
// ----------------------------------------------------------------------------
// flag_escape_deframer_top
// removes 0x7E flags and 0x7D escapes from a received byte stream, emits
// payload bytes, frame ends with raw length, and aborts for over-long frames
// ----------------------------------------------------------------------------
//  channel   dir  signals                     content
//  s_axis    in   tvalid tready tdata[7:0]    rx_byte
//  m_axis    out  tvalid tready tdata tuser   data byte, error, length / kind
//  cfg       in   valid ready data[23:0]      max_raw_length
//
//  one beat in per cycle sustained while m_axis does not stall; a beat is
//  held in the input register, is decoded on the move into the output
//  register, and any result it yields is offered on m_axis from there.
//  reset clears the frame state, the pipeline valids and loads the limit
//  with 10485760. a stall on m_axis holds the output register; the input
//  register takes a beat while it is empty or while its own beat can move on.
// ----------------------------------------------------------------------------
module flag_escape_deframer_top
  import fed_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // input stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [7:0]            s_axis_tdata,   // [7:0] rx_byte
  // result stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [7:0] data_byte, [8] escape_error,
                                                // [32:9] frame_raw_length, rest zero
  output logic [1:0]            m_axis_tuser,   // [1:0] result_kind
  // limit register write
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [LEN_W-1:0]      cfg_data_i
);

  // limit register
  logic [LEN_W-1:0] max_len_q;

  // input register
  logic       in_valid_q;
  logic [7:0] in_byte_q;

  // frame state
  logic             esc_pend_q, esc_pend_d;
  logic             bad_esc_q, bad_esc_d;
  logic [LEN_W-1:0] raw_cnt_q, raw_cnt_d;

  // output register
  logic             out_valid_q;
  kind_e            out_kind_q;
  logic [7:0]       out_byte_q;
  logic             out_err_q;
  logic [LEN_W-1:0] out_len_q;

  // decode result
  logic             res_valid;
  kind_e            res_kind;
  logic [7:0]       res_byte;
  logic             res_err;
  logic [LEN_W-1:0] res_len;

  logic consume;

  // pipeline handshake
  assign consume       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || consume;
  assign cfg_ready_o   = 1'b1;

  // limit register write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= LIMIT_RESET;
    end else if (cfg_valid_i) begin
      max_len_q <= cfg_data_i;
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
    end
  end

  // byte decode and frame state update
  always_comb begin
    esc_pend_d = esc_pend_q;
    bad_esc_d  = bad_esc_q;
    raw_cnt_d  = raw_cnt_q;
    res_valid  = 1'b0;
    res_kind   = KIND_DATA;
    res_byte   = '0;
    res_err    = 1'b0;
    res_len    = '0;
    if (in_byte_q == FLAG_BYTE) begin
      // flag: close frame if it holds anything
      esc_pend_d = 1'b0;
      bad_esc_d  = 1'b0;
      raw_cnt_d  = '0;
      if (raw_cnt_q != '0) begin
        res_valid = 1'b1;
        res_kind  = KIND_END;
        res_err   = bad_esc_q;
        res_len   = raw_cnt_q;
      end
    end else if (raw_cnt_q >= max_len_q) begin
      // frame too long
      esc_pend_d = 1'b0;
      bad_esc_d  = 1'b0;
      raw_cnt_d  = '0;
      res_valid  = 1'b1;
      res_kind   = KIND_ABORT;
    end else begin
      raw_cnt_d = raw_cnt_q + 1'b1;
      if (esc_pend_q) begin
        // second byte of an escape pair
        esc_pend_d = 1'b0;
        if (in_byte_q == ESC_FLAG_CODE) begin
          res_valid = 1'b1;
          res_byte  = FLAG_BYTE;
        end else if (in_byte_q == ESC_ESC_CODE) begin
          res_valid = 1'b1;
          res_byte  = ESC_BYTE;
        end else begin
          bad_esc_d = 1'b1;
        end
      end else if (in_byte_q == ESC_BYTE) begin
        esc_pend_d = 1'b1;
      end else begin
        res_valid = 1'b1;
        res_byte  = in_byte_q;
      end
    end
  end

  // frame state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_pend_q <= 1'b0;
      bad_esc_q  <= 1'b0;
      raw_cnt_q  <= '0;
    end else if (consume) begin
      esc_pend_q <= esc_pend_d;
      bad_esc_q  <= bad_esc_d;
      raw_cnt_q  <= raw_cnt_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (consume) begin
      out_valid_q <= res_valid;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (consume && res_valid) begin
      out_kind_q <= res_kind;
      out_byte_q <= res_byte;
      out_err_q  <= res_err;
      out_len_q  <= res_len;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tdata  = OUT_DATA_W'({out_len_q, out_err_q, out_byte_q});

  // a pending escape always sits inside a counted frame
  a_esc_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    esc_pend_q |-> raw_cnt_q != '0)
    else $error("escape pending with empty frame");

  // only frame ends carry length and error
  a_end_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_kind_q != KIND_END) |-> (out_len_q == '0 && !out_err_q))
    else $error("length or error on a non frame-end result");

  // an abort or frame end restarts the frame
  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (consume && res_valid && res_kind != KIND_DATA) |=>
      (raw_cnt_q == '0 && !esc_pend_q && !bad_esc_q))
    else $error("frame state not cleared after end or abort");

  // a frame end never reports an empty frame
  a_end_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_kind_q == KIND_END) |-> out_len_q != '0)
    else $error("frame end with zero length");

endmodule
